@@ design/rbd_pkg.sv @@
// Shared constants, register codes and the control record of the RGB box downsampler.
// Used by every module in this folder; depends on nothing.
package rbd_pkg;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_FACTOR = 16;
  localparam int MAX_HEIGHT     = 4096;

  localparam int PIX_W  = 8;   // one color channel
  localparam int DIM_W  = 13;  // image_width / image_height registers
  localparam int FACT_W = 5;   // shrink_factor register
  localparam int CFG_W  = 13;  // widest register
  localparam int IDX_W  = 2;
  localparam int ROW_W  = 12;  // row position, height is at most 4096

  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [IDX_W-1:0] REG_SHRINK_FACTOR = 2'd2;

  localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH   = 13'd640;
  localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT  = 13'd480;
  localparam logic [FACT_W-1:0] RST_SHRINK_FACTOR = 5'd2;

  // What the position tracker says about the pixel at the input.
  typedef struct packed {
    logic first_col;   // first column inside its block
    logic first_row;   // first row inside its block
    logic write_col;   // last column of a full block: column sum is updated
    logic block_done;  // bottom-right pixel of a full block: a result leaves
    logic frame_end;   // that result is the last one of the frame
  } rbd_ctl_t;

endpackage

@@ design/rbd_ctrl.sv @@
// Configuration registers and frame position tracking of the RGB box downsampler.
// Depends on rbd_pkg.
module rbd_ctrl #(
  parameter int MAX_WIDTH  = rbd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_FACTOR = rbd_pkg::DEF_MAX_FACTOR,
  localparam int ADDRW = $clog2(MAX_WIDTH / 2),
  localparam int AW    = $clog2(MAX_FACTOR * MAX_FACTOR + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [rbd_pkg::IDX_W-1:0]  cfg_index,
  input  logic [rbd_pkg::CFG_W-1:0]  cfg_data,
  input  logic                       accept,
  output rbd_pkg::rbd_ctl_t          ctl,
  output logic [ADDRW-1:0]           addr,
  output logic [AW-1:0]              area
);
  import rbd_pkg::*;

  localparam int PW   = $clog2(MAX_WIDTH + 1);
  localparam int EW   = (PW > DIM_W) ? PW : DIM_W;
  localparam int DW   = EW + 1;
  localparam int COLW = $clog2(MAX_WIDTH);
  localparam int CW   = $clog2(MAX_FACTOR);

  logic [DIM_W-1:0]  image_width;
  logic [DIM_W-1:0]  image_height;
  logic [FACT_W-1:0] shrink_factor;

  logic [COLW-1:0]  col;
  logic [COLW-1:0]  bcol;
  logic [ROW_W-1:0] row;
  logic [CW-1:0]    cib;
  logic [CW-1:0]    rib;

  logic [DW-1:0]   w_raw, h_raw, f_raw;
  logic [DW-1:0]   w_e, h_e, f_e;
  logic [2*DW-1:0] area_full;
  logic            col_full, row_full, col_last, row_last, cib_last, rib_last;
  logic            restart;

  assign w_raw = DW'(image_width);
  assign h_raw = DW'(image_height);
  assign f_raw = DW'(shrink_factor);

  always_comb begin
    w_e = (w_raw == '0) ? DW'(1) : ((w_raw > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : w_raw);
    h_e = (h_raw == '0) ? DW'(1) : ((h_raw > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : h_raw);
    f_e = (f_raw == '0) ? DW'(1) : ((f_raw > DW'(MAX_FACTOR)) ? DW'(MAX_FACTOR) : f_raw);
  end

  assign area_full = f_e * f_e;

  // A block is full when it ends inside the image; its start is pos - offset.
  assign col_full = (w_e - DW'(col) + DW'(cib)) >= f_e;
  assign row_full = (h_e - DW'(row) + DW'(rib)) >= f_e;
  assign col_last = (w_e - DW'(col)) <= f_e;
  assign row_last = (h_e - DW'(row)) <= f_e;
  assign cib_last = DW'(cib) == (f_e - DW'(1));
  assign rib_last = DW'(rib) == (f_e - DW'(1));

  always_comb begin
    ctl.first_col  = (cib == '0);
    ctl.first_row  = (rib == '0);
    ctl.write_col  = col_full && row_full && cib_last;
    ctl.block_done = col_full && row_full && cib_last && rib_last;
    ctl.frame_end  = col_full && row_full && cib_last && rib_last && col_last && row_last;
  end

  assign addr = bcol[ADDRW-1:0];

  assign restart = cfg_we && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT ||
                              cfg_index == REG_SHRINK_FACTOR);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= RST_IMAGE_WIDTH;
      image_height  <= RST_IMAGE_HEIGHT;
      shrink_factor <= RST_SHRINK_FACTOR;
      area          <= AW'(4);
    end else begin
      area <= area_full[AW-1:0];
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:   image_width   <= cfg_data[DIM_W-1:0];
          REG_IMAGE_HEIGHT:  image_height  <= cfg_data[DIM_W-1:0];
          REG_SHRINK_FACTOR: shrink_factor <= cfg_data[FACT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col  <= '0;
      bcol <= '0;
      row  <= '0;
      cib  <= '0;
      rib  <= '0;
    end else if (accept) begin
      if ((DW'(col) + DW'(1)) >= w_e) begin
        col  <= '0;
        bcol <= '0;
        cib  <= '0;
        if ((DW'(row) + DW'(1)) >= h_e) begin
          row <= '0;
          rib <= '0;
        end else begin
          row <= row + ROW_W'(1);
          rib <= rib_last ? '0 : rib + CW'(1);
        end
      end else begin
        col  <= col + COLW'(1);
        cib  <= cib_last ? '0 : cib + CW'(1);
        bcol <= cib_last ? bcol + COLW'(1) : bcol;
      end
    end
  end

endmodule

@@ design/rbd_lane.sv @@
// One color channel: row-wise block sum, per-column sum memory and a pipelined
// restoring divider by the block area. Depends on rbd_pkg.
module rbd_lane #(
  parameter int MAX_WIDTH  = rbd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_FACTOR = rbd_pkg::DEF_MAX_FACTOR,
  localparam int ADDRW = $clog2(MAX_WIDTH / 2),
  localparam int AW    = $clog2(MAX_FACTOR * MAX_FACTOR + 1)
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic                      accept,
  input  logic [rbd_pkg::PIX_W-1:0] pix,
  input  rbd_pkg::rbd_ctl_t         ctl,
  input  logic [ADDRW-1:0]          addr,
  input  logic [AW-1:0]             area,
  output logic [rbd_pkg::PIX_W-1:0] quo
);
  import rbd_pkg::*;

  localparam int DEPTH = MAX_WIDTH / 2;
  localparam int HW    = $clog2(MAX_FACTOR * 255 + 1);
  localparam int SUMW  = $clog2(MAX_FACTOR * MAX_FACTOR * 255 + 1);
  localparam int XW    = SUMW + PIX_W;

  logic [HW-1:0]   hsum;
  logic [HW-1:0]   hsum_next;
  logic [SUMW-1:0] col_mem [0:DEPTH-1];
  logic [SUMW-1:0] rdata;
  logic [SUMW-1:0] col_total;

  logic [SUMW-1:0]  rem [0:PIX_W];
  logic [PIX_W-1:0] qt  [0:PIX_W];
  logic [XW-1:0]    dvs [1:PIX_W];
  logic [PIX_W:1]   take;

  assign hsum_next = ctl.first_col ? HW'(pix) : hsum + HW'(pix);
  assign col_total = (ctl.first_row ? '0 : rdata) + SUMW'(hsum_next);

  // Column sum is read at the block's first column and written back at its last.
  always_ff @(posedge clk) begin
    if (accept) begin
      hsum <= hsum_next;
      if (ctl.first_col)
        rdata <= col_mem[addr];
      if (ctl.write_col)
        col_mem[addr] <= col_total;
    end
  end

  always_comb begin
    for (int s = 1; s <= PIX_W; s++) begin
      dvs[s]  = XW'(area) << (PIX_W - s);
      take[s] = XW'(rem[s-1]) >= dvs[s];
    end
  end

  // One quotient bit per stage, MSB first; the mean never exceeds 255.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= col_total;
      qt[0]  <= '0;
      for (int s = 1; s <= PIX_W; s++) begin
        rem[s] <= take[s] ? rem[s-1] - dvs[s][SUMW-1:0] : rem[s-1];
        qt[s]  <= qt[s-1] | (PIX_W'(take[s]) << (PIX_W - s));
      end
    end
  end

  assign quo = qt[PIX_W];

endmodule

@@ design/rbd_merge.sv @@
// Valid and frame-end tracking alongside the lane dividers, and the output
// register that joins the three channel results. Depends on rbd_pkg.
module rbd_merge (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        frame_end,
  input  logic [rbd_pkg::PIX_W-1:0]   quo_red,
  input  logic [rbd_pkg::PIX_W-1:0]   quo_green,
  input  logic [rbd_pkg::PIX_W-1:0]   quo_blue,
  output logic                        en,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [3*rbd_pkg::PIX_W-1:0] m_tdata,
  output logic                        m_tlast
);
  import rbd_pkg::*;

  localparam int STAGES = PIX_W + 1;

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] fe;

  // The whole pipeline moves together unless the result at the end is held.
  assign en = !vld[STAGES-1] || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    if (en)
      fe <= {fe[STAGES-2:0], frame_end};
  end

  assign m_tvalid = vld[STAGES-1];
  assign m_tlast  = fe[STAGES-1];
  assign m_tdata  = {quo_blue, quo_green, quo_red};

endmodule

@@ design/rgb_box_downsampler_unit.sv @@
// Top level of the RGB box downsampler: position tracker, three channel lanes
// and the output merge. Depends on rbd_pkg, rbd_ctrl, rbd_lane, rbd_merge.

// Raster-order RGB pixels come in one per clock and each full factor-by-factor
// block leaves as one averaged pixel (truncated mean per channel); pixels past
// the last full block row or column are taken and dropped, and factor 1 passes
// pixels through. A pixel is accepted every cycle that the output is not held;
// a result follows the pixel that completes its block: the block sum is
// captured at the accepting edge, then each channel's divider resolves one
// quotient bit per cycle while the output is not held. Column sums live in one
// MAX_WIDTH/2-entry memory per channel, read at each block's first column and
// written at its last. A write to any of the three registers restarts the
// frame; write registers only while idle.
module rgb_box_downsampler_unit #(
  parameter int MAX_WIDTH  = rbd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_FACTOR = rbd_pkg::DEF_MAX_FACTOR
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [rbd_pkg::IDX_W-1:0]   cfg_index,
  input  logic [rbd_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [3*rbd_pkg::PIX_W-1:0] s_tdata,   // pixel_red, pixel_green, pixel_blue
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [3*rbd_pkg::PIX_W-1:0] m_tdata,   // avg_red, avg_green, avg_blue
  output logic                        m_tlast    // frame_end
);
  import rbd_pkg::*;

  localparam int ADDRW = $clog2(MAX_WIDTH / 2);
  localparam int AW    = $clog2(MAX_FACTOR * MAX_FACTOR + 1);

  rbd_ctl_t         ctl;
  logic [ADDRW-1:0] addr;
  logic [AW-1:0]    area;
  logic             en;
  logic             accept;
  logic [PIX_W-1:0] quo_red, quo_green, quo_blue;

  assign s_tready = en;
  assign accept   = s_tvalid && en;

  rbd_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_FACTOR(MAX_FACTOR)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .accept   (accept),
    .ctl      (ctl),
    .addr     (addr),
    .area     (area)
  );

  rbd_lane #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_FACTOR(MAX_FACTOR)
  ) u_lane_red (
    .clk   (clk),
    .en    (en),
    .accept(accept),
    .pix   (s_tdata[PIX_W-1:0]),
    .ctl   (ctl),
    .addr  (addr),
    .area  (area),
    .quo   (quo_red)
  );

  rbd_lane #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_FACTOR(MAX_FACTOR)
  ) u_lane_green (
    .clk   (clk),
    .en    (en),
    .accept(accept),
    .pix   (s_tdata[2*PIX_W-1:PIX_W]),
    .ctl   (ctl),
    .addr  (addr),
    .area  (area),
    .quo   (quo_green)
  );

  rbd_lane #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_FACTOR(MAX_FACTOR)
  ) u_lane_blue (
    .clk   (clk),
    .en    (en),
    .accept(accept),
    .pix   (s_tdata[3*PIX_W-1:2*PIX_W]),
    .ctl   (ctl),
    .addr  (addr),
    .area  (area),
    .quo   (quo_blue)
  );

  rbd_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && ctl.block_done),
    .frame_end(ctl.frame_end),
    .quo_red  (quo_red),
    .quo_green(quo_green),
    .quo_blue (quo_blue),
    .en       (en),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // a held result freezes the whole pipeline, so no request may enter
  a_hold_blocks_input: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("request accepted while a result is held");

  // frame end is only ever flagged on a completed block
  a_frame_end_on_block: assert property (@(posedge clk) disable iff (rst)
    ctl.frame_end |-> ctl.block_done && ctl.write_col)
    else $error("frame end flagged outside a completed block");

  // a stalled result stays put until it is taken
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("held result changed before it was taken");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for rgb_box_downsampler_unit: random pixel streams over many geometries.
// Depends on rbd_pkg and the design; the expected block means come from a predictor kept here.
module tb;
  import rbd_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int SUM_DEPTH   = DEF_MAX_WIDTH / 2;
  localparam int DRAIN       = 24;  // pipeline is 9 deep, leave margin
  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum int {PIX_ANY, PIX_EXTREME, PIX_WHITE, PIX_HIGH} pix_style_t;
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } block_mean_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [IDX_W-1:0]     cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [3*PIX_W-1:0]   s_tdata   = '0;  // pixel_red, pixel_green, pixel_blue
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [3*PIX_W-1:0]   m_tdata;         // avg_red, avg_green, avg_blue
  logic                 m_tlast;         // frame_end

  rgb_box_downsampler_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #4 clk = ~clk;

  // Predictor state
  logic [DIM_W-1:0]  reg_width  = RST_IMAGE_WIDTH;
  logic [DIM_W-1:0]  reg_height = RST_IMAGE_HEIGHT;
  logic [FACT_W-1:0] reg_factor = RST_SHRINK_FACTOR;
  logic [15:0]       red_sum   [SUM_DEPTH];
  logic [15:0]       green_sum [SUM_DEPTH];
  logic [15:0]       blue_sum  [SUM_DEPTH];
  logic [11:0]       col_pos    = '0;
  logic [11:0]       row_pos    = '0;
  logic [3:0]        col_in_blk = '0;
  logic [3:0]        row_in_blk = '0;

  logic [3*PIX_W-1:0] pixel_queue [$];
  block_mean_t        block_means [$];
  int unsigned        block_count = 0;
  int unsigned        mismatches  = 0;
  int unsigned        cycle_count = 0;

  function automatic int unsigned limit_dim(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  task automatic apply_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    case (idx)
      REG_IMAGE_WIDTH:   reg_width  = val;
      REG_IMAGE_HEIGHT:  reg_height = val;
      REG_SHRINK_FACTOR: reg_factor = val[FACT_W-1:0];
      default:           return;
    endcase
    col_pos    = '0;
    row_pos    = '0;
    col_in_blk = '0;
    row_in_blk = '0;
  endtask

  task automatic downsample_pixel(input logic [3*PIX_W-1:0] pix);
    int unsigned w, h, f, col, row, full_w, full_h, idx, area, cib, rib;
    logic [7:0]  r, g, b;
    block_mean_t m;
    w = limit_dim(reg_width, DEF_MAX_WIDTH);
    h = limit_dim(reg_height, MAX_HEIGHT);
    f = limit_dim(reg_factor, DEF_MAX_FACTOR);
    r = pix[7:0];
    g = pix[15:8];
    b = pix[23:16];
    col = col_pos;
    row = row_pos;
    cib = col_in_blk;
    rib = row_in_blk;
    if (col >= w) col = 0;
    if (row >= h) row = 0;
    full_w = (w / f) * f;
    full_h = (h / f) * f;
    if (f == 1) begin
      m.red       = r;
      m.green     = g;
      m.blue      = b;
      m.frame_end = (col == w - 1) && (row == h - 1);
      block_means.push_back(m);
      block_count++;
    end else if (col < full_w && row < full_h) begin
      idx = (col / f) % SUM_DEPTH;
      if (cib == 0 && rib == 0) begin
        red_sum[idx]   = r;
        green_sum[idx] = g;
        blue_sum[idx]  = b;
      end else begin
        red_sum[idx]   = red_sum[idx] + r;
        green_sum[idx] = green_sum[idx] + g;
        blue_sum[idx]  = blue_sum[idx] + b;
      end
      if (cib == f - 1 && rib == f - 1) begin
        area        = f * f;
        m.red       = 8'(red_sum[idx] / area);
        m.green     = 8'(green_sum[idx] / area);
        m.blue      = 8'(blue_sum[idx] / area);
        m.frame_end = (col == full_w - 1) && (row == full_h - 1);
        block_means.push_back(m);
        block_count++;
      end
    end
    col++;
    cib = (cib + 1 >= f) ? 0 : cib + 1;
    if (col >= w) begin
      col = 0;
      cib = 0;
      row++;
      rib = (rib + 1 >= f) ? 0 : rib + 1;
      if (row >= h) begin
        row = 0;
        rib = 0;
      end
    end
    col_pos    = 12'(col);
    row_pos    = 12'(row);
    col_in_blk = 4'(cib);
    row_in_blk = 4'(rib);
  endtask

  // Sender: bursts of requests separated by random gaps
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) downsample_pixel(s_tdata);
      if (!s_tvalid || s_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pixel_queue.size() != 0) begin
          s_tdata  <= pixel_queue.pop_front();
          s_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 20);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each taken result and switches among four stall patterns
  rx_mode_t    rx_mode    = RX_OPEN;
  int unsigned rx_left    = 0;
  int unsigned stall_left = 0;

  always @(posedge clk) begin
    block_mean_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      if (block_means.size() == 0) begin
        $error("unrequested result: red %0d green %0d blue %0d frame_end %0b",
               m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tlast);
        mismatches++;
      end else begin
        want = block_means.pop_front();
        if (m_tdata[7:0] !== want.red) begin
          $error("avg_red: expected %0d, got %0d", want.red, m_tdata[7:0]);
          mismatches++;
        end
        if (m_tdata[15:8] !== want.green) begin
          $error("avg_green: expected %0d, got %0d", want.green, m_tdata[15:8]);
          mismatches++;
        end
        if (m_tdata[23:16] !== want.blue) begin
          $error("avg_blue: expected %0d, got %0d", want.blue, m_tdata[23:16]);
          mismatches++;
        end
        if (m_tlast !== want.frame_end) begin
          $error("frame_end: expected %0b, got %0b", want.frame_end, m_tlast);
          mismatches++;
        end
      end
    end
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(50, 400);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:   m_tready <= 1'b1;
      RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_tready <= (rx_left % 4 == 0);
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
          if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 16);
        end
      end
    endcase
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [3*PIX_W-1:0] make_pixel(pix_style_t style);
    case (style)
      PIX_EXTREME: return {{8{1'($urandom_range(0, 1))}}, {8{1'($urandom_range(0, 1))}},
                           {8{1'($urandom_range(0, 1))}}};
      PIX_WHITE:   return '1;
      PIX_HIGH:    return {8'($urandom_range(240, 255)), 8'($urandom_range(240, 255)),
                           8'($urandom_range(240, 255))};
      default:     return 24'($urandom);
    endcase
  endfunction

  task automatic send_pixels(input int unsigned n, input pix_style_t style);
    for (int unsigned i = 0; i < n; i++) pixel_queue.push_back(make_pixel(style));
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_register(idx, val);
  endtask

  // Block until every queued pixel is taken and every result is back, then drain.
  task automatic settle();
    while (pixel_queue.size() != 0 || s_tvalid || block_means.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  initial begin
    int unsigned w, h, f, ew, eh, n, first, frame_px, phase, random_px;
    logic [CFG_W-1:0] fdata;
    pix_style_t style;
    random_px = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset geometry: a few pixels, no block can finish yet
    send_pixels(4, PIX_ANY);
    settle();

    // pass-through 3x2, then one pixel of the next frame
    write_reg(REG_IMAGE_WIDTH, 13'd3);
    write_reg(REG_IMAGE_HEIGHT, 13'd2);
    write_reg(REG_SHRINK_FACTOR, 13'd1);
    pixel_queue.push_back(24'h000000);
    pixel_queue.push_back(24'hFFFFFF);
    pixel_queue.push_back(24'h0F0F0F);
    pixel_queue.push_back(24'hF0F0F0);
    pixel_queue.push_back(24'h123456);
    pixel_queue.push_back(24'hFEDCBA);
    pixel_queue.push_back(24'h5A5A5A);
    settle();

    // zero registers read as 1x1, factor 1: every pixel ends a frame
    write_reg(REG_IMAGE_WIDTH, '0);
    write_reg(REG_IMAGE_HEIGHT, '0);
    write_reg(REG_SHRINK_FACTOR, '0);
    send_pixels(3, PIX_EXTREME);
    settle();

    // image smaller than a block, oversized factor saturates
    write_reg(REG_IMAGE_WIDTH, 13'd2);
    write_reg(REG_IMAGE_HEIGHT, 13'd1);
    write_reg(REG_SHRINK_FACTOR, 13'd31);
    send_pixels(2, PIX_ANY);
    settle();

    // 2x2 block of full white, write to the unused index in the middle
    write_reg(REG_SHRINK_FACTOR, 13'd2);
    write_reg(REG_IMAGE_HEIGHT, 13'd2);
    send_pixels(2, PIX_WHITE);
    settle();
    write_reg(REG_UNUSED, 13'h1FFF);
    send_pixels(2, PIX_WHITE);
    settle();

    // a write mid-frame restarts it
    send_pixels(2, PIX_ANY);
    settle();
    write_reg(REG_IMAGE_WIDTH, 13'd2);
    send_pixels(4, PIX_ANY);
    settle();

    phase = 0;
    while (random_px < 1700 || block_count < 60) begin
      case ($urandom_range(0, 9))
        0:       w = 0;
        1:       w = $urandom_range(33, 100);
        default: w = $urandom_range(1, 32);
      endcase
      h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 16);
      case ($urandom_range(0, 19))
        0:             f = 0;
        1:             f = $urandom_range(17, 31);
        2, 3:          f = 1;
        4, 5, 6:       f = $urandom_range(9, 16);
        default:       f = $urandom_range(2, 8);
      endcase
      fdata = ($urandom_range(0, 3) == 0) ? {8'($urandom), 5'(f)} : 13'(f);
      first = $urandom_range(0, 2);
      for (int k = 0; k < 3; k++) begin
        case (IDX_W'((first + k) % 3))
          REG_IMAGE_WIDTH:  write_reg(REG_IMAGE_WIDTH, 13'(w));
          REG_IMAGE_HEIGHT: write_reg(REG_IMAGE_HEIGHT, 13'(h));
          default:          write_reg(REG_SHRINK_FACTOR, fdata);
        endcase
      end
      ew = (w == 0) ? 1 : w;
      eh = (h == 0) ? 1 : h;
      frame_px = ew * eh;
      n = frame_px;
      if (frame_px <= 200 && $urandom_range(0, 2) == 0) n += frame_px;
      // trailing partial frame, cut off by the next phase's writes
      if ($urandom_range(0, 2) == 0) n += $urandom_range(0, frame_px - 1);
      if (n > 600) n = 600;
      style = pix_style_t'($urandom_range(0, 3));
      if (phase == 0 || $urandom_range(0, 5) == 0) begin
        // sender holds off until everything in flight has come back
        send_pixels(n / 2, style);
        settle();
        if ($urandom_range(0, 1) == 0) write_reg(REG_UNUSED, 13'($urandom));
        send_pixels(n - n / 2, style);
      end else begin
        send_pixels(n, style);
      end
      settle();
      random_px += n;
      phase++;
    end

    // oversized width and height saturate; pass-through, no frame end this early
    write_reg(REG_IMAGE_WIDTH, 13'h1FFF);
    write_reg(REG_IMAGE_HEIGHT, 13'h1FFF);
    write_reg(REG_SHRINK_FACTOR, 13'd1);
    send_pixels(64, PIX_ANY);
    settle();

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
